@@ hw/rtl/srs_pkg.sv @@
// Package for the selective-repeat sender scoreboard.
// Holds the sizing constants, the code enums and the controller/datapath structs.
// Depends on nothing; srs_ctrl, srs_dp, srs_checker and the top level import it.
package srs_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int STAMP_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COUNT_W    = 7;
	localparam int ACK_W      = 8;
	localparam int CHIDX_W    = 8;
	localparam int AGE_W      = 16;
	localparam int AGE_RESET  = 100;
	localparam int CMP_W      = (STAMP_BITS > AGE_W) ? STAMP_BITS : AGE_W;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_ACK   = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_SCAN  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_SEND   = 2'd0,
		KIND_RETX   = 2'd1,
		KIND_STATUS = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_EVAL,
		ST_FLUSH,
		ST_ACK
	} state_t;

	typedef enum logic [2:0] {
		OSEL_SEND,
		OSEL_STATUS,
		OSEL_RETX_MID,
		OSEL_RETX_LAST,
		OSEL_DONE
	} out_sel_t;

	typedef struct packed {
		logic     start_load;
		logic     ack_read;
		logic     ack_update;
		logic     tick_inc;
		logic     scan_init;
		logic     out_load;
		out_sel_t out_sel;
		logic     idx_inc;
		logic     stamp_we;
		logic     pend_set;
		logic     read_next;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  count_zero;
		logic  msg_zero;
		logic  out_free;
		logic  idx_last;
		logic  due;
		logic  pend_valid;
	} stat_t;

endpackage

@@ hw/rtl/srs_in_if.sv @@
// Input channel of the scoreboard: valid/ready handshake with the item fields.
// Depends on nothing.
interface srs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [6:0] chunk_count;
	logic [7:0] ack_index;

	modport source (output valid, output func, output chunk_count, output ack_index,
		input ready);
	modport sink (input valid, input func, input chunk_count, input ack_index,
		output ready);
endinterface

@@ hw/rtl/srs_out_if.sv @@
// Result channel of the scoreboard: valid/ready handshake with the result fields.
// Depends on nothing.
interface srs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] chunk_index;
	logic       all_acked;
	logic       duplicate_ack;
	logic       bad_index;
	logic       last;

	modport source (output valid, output kind, output chunk_index, output all_acked,
		output duplicate_ack, output bad_index, output last, input ready);
	modport sink (input valid, input kind, input chunk_index, input all_acked,
		input duplicate_ack, input bad_index, input last, output ready);
endinterface

@@ hw/rtl/selective_repeat_sender_scoreboard_unit.sv @@
// Top level of the selective-repeat sender scoreboard.
// Depends on srs_pkg, srs_in_if, srs_out_if, srs_ctrl and srs_dp.
//
// Items arrive on in_ch and results leave on out_ch; both use valid/ready, and a
// transaction happens at a rising edge with valid and ready both high. The age
// register is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. A start
// transaction produces one send result per chunk, one per cycle while the result
// register is free; each send also clears that chunk's acknowledge entry. An
// acknowledge first reads its entry of the acknowledge RAM, then loads its status
// result into the result register. A tick produces no result. A scan reads the
// stamp and acknowledge RAMs one entry per cycle unless a due chunk waits on a
// busy result register; the single read port of each RAM sets that rate.
// Retransmit results lag their chunk, because each is held until the next due
// chunk or the end of the scan decides its last flag. Reset clears time, counters
// and the state machine and sets the age to 100 ticks; neither RAM is cleared, as
// only entries of the current message are ever used. When the receiver stalls,
// the result register holds its transaction and the block waits; a new item is
// taken only once the result register is free or being emptied.
module selective_repeat_sender_scoreboard_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	srs_in_if.sink                      in_ch,
	srs_out_if.source                   out_ch,
	input  logic                        cfg_we,
	input  logic [srs_pkg::AGE_W-1:0]   cfg_wdata
);
	import srs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srs_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_func           (in_ch.func),
		.in_chunk_count    (in_ch.chunk_count),
		.in_ack_index      (in_ch.ack_index),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_ready         (out_ch.ready),
		.out_valid         (out_ch.valid),
		.out_kind          (out_ch.kind),
		.out_chunk_index   (out_ch.chunk_index),
		.out_all_acked     (out_ch.all_acked),
		.out_duplicate_ack (out_ch.duplicate_ack),
		.out_bad_index     (out_ch.bad_index),
		.out_last          (out_ch.last)
	);

endmodule

@@ hw/rtl/srs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/srs_ctrl.sv @@
// Controller state machine of the scoreboard: sequences start, acknowledge,
// tick and scan transactions. Depends on srs_pkg.
module srs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  srs_pkg::stat_t stat,
	output srs_pkg::cmd_t  cmd
);
	import srs_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;
	logic   stall;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;
	assign stall    = stat.due && stat.pend_valid && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && stat.func == FUNC_START && !stat.count_zero) begin
					state_nxt = ST_SEND;
				end else if (accept && stat.func == FUNC_ACK) begin
					state_nxt = ST_ACK;
				end else if (accept && stat.func == FUNC_SCAN && !stat.msg_zero) begin
					state_nxt = ST_EVAL;
				end
			end
			ST_SEND: begin
				if (stat.out_free && stat.idx_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EVAL: begin
				if (!stall && stat.idx_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ACK: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_sel = OSEL_SEND;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (stat.func)
						FUNC_START: cmd.start_load = 1'b1;
						FUNC_ACK: cmd.ack_read = 1'b1;
						FUNC_TICK: cmd.tick_inc = 1'b1;
						FUNC_SCAN: begin
							cmd.scan_init = 1'b1;
							if (stat.msg_zero) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = OSEL_DONE;
							end
						end
						default: cmd.out_load = 1'b0;
					endcase
				end
			end
			ST_SEND: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_SEND;
					cmd.stamp_we = 1'b1;
					cmd.idx_inc  = 1'b1;
				end
			end
			ST_EVAL: begin
				if (!stall) begin
					cmd.idx_inc   = 1'b1;
					cmd.read_next = 1'b1;
					if (stat.due) begin
						cmd.stamp_we = 1'b1;
						cmd.pend_set = 1'b1;
						if (stat.pend_valid) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = OSEL_RETX_MID;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = stat.pend_valid ? OSEL_RETX_LAST : OSEL_DONE;
				end
			end
			ST_ACK: begin
				if (stat.out_free) begin
					cmd.ack_update = 1'b1;
					cmd.out_load   = 1'b1;
					cmd.out_sel    = OSEL_STATUS;
				end
			end
			default: cmd.out_load = 1'b0;
		endcase
	end

endmodule

@@ hw/rtl/srs_dp.sv @@
// Datapath of the scoreboard: message registers, acknowledge and stamp RAMs,
// pending retransmit and the result register. Depends on srs_pkg and srs_ram.
module srs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srs_pkg::cmd_t                  cmd,
	output srs_pkg::stat_t                 stat,
	input  logic [1:0]                     in_func,
	input  logic [srs_pkg::COUNT_W-1:0]    in_chunk_count,
	input  logic [srs_pkg::ACK_W-1:0]      in_ack_index,
	input  logic                           cfg_we,
	input  logic [srs_pkg::AGE_W-1:0]      cfg_wdata,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [1:0]                     out_kind,
	output logic [srs_pkg::CHIDX_W-1:0]    out_chunk_index,
	output logic                           out_all_acked,
	output logic                           out_duplicate_ack,
	output logic                           out_bad_index,
	output logic                           out_last
);
	import srs_pkg::*;

	logic [AGE_W-1:0]      age_q;
	logic [STAMP_BITS-1:0] tick_q;
	logic [COUNT_W-1:0]    total_q;
	logic [COUNT_W-1:0]    msg_q;
	logic [ACK_W-1:0]      ack_idx_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  pend_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [CHIDX_W-1:0]    chunk_index_q;
	logic                  all_acked_q;
	logic                  dup_q;
	logic                  bad_q;
	logic                  last_q;

	logic [COUNT_W-1:0]    count_sat;
	logic                  ack_bad;
	logic                  ack_dup;
	logic [COUNT_W-1:0]    total_inc;
	logic                  ack_all;
	logic [IDX_W-1:0]      ack_slot;
	logic [IDX_W-1:0]      cur_slot;
	logic [CNT_W-1:0]      idx_inc;
	logic [IDX_W-1:0]      raddr;
	logic [STAMP_BITS-1:0] stamp_rd;
	logic [STAMP_BITS-1:0] age_now;
	logic                  out_free;
	logic                  map_rd;
	logic                  map_set;
	logic                  map_we;
	logic [IDX_W-1:0]      map_waddr;

	assign out_free  = !out_valid_q || out_ready;
	assign count_sat = (in_chunk_count > COUNT_W'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS)
		: in_chunk_count;
	assign ack_slot  = ack_idx_q[IDX_W-1:0];
	assign cur_slot  = idx_q[IDX_W-1:0];
	assign ack_bad   = ack_idx_q >= ACK_W'(msg_q);
	assign ack_dup   = !ack_bad && map_rd;
	assign total_inc = total_q + 1'b1;
	assign ack_all   = (ack_bad || ack_dup) ? (total_q == msg_q) : (total_inc == msg_q);
	assign idx_inc   = idx_q + 1'b1;
	assign age_now   = tick_q - stamp_rd;
	assign map_set   = cmd.ack_update && !ack_bad && !ack_dup;
	assign map_we    = cmd.stamp_we || map_set;
	assign map_waddr = map_set ? ack_slot : cur_slot;

	always_comb begin
		if (cmd.read_next) begin
			raddr = idx_inc[IDX_W-1:0];
		end else if (cmd.scan_init) begin
			raddr = '0;
		end else if (cmd.ack_read) begin
			raddr = in_ack_index[IDX_W-1:0];
		end else begin
			raddr = cur_slot;
		end
	end

	srs_ram #(
		.WIDTH (STAMP_BITS),
		.DEPTH (MAX_CHUNKS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (cmd.stamp_we),
		.waddr (cur_slot),
		.wdata (tick_q),
		.raddr (raddr),
		.rdata (stamp_rd)
	);

	// Each send clears its chunk's entry, so a new message never sees stale marks.
	srs_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CHUNKS)
	) u_ack_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_set),
		.raddr (raddr),
		.rdata (map_rd)
	);

	always_comb begin
		stat.func       = func_t'(in_func);
		stat.count_zero = (in_chunk_count == '0);
		stat.msg_zero   = (msg_q == '0);
		stat.out_free   = out_free;
		stat.idx_last   = (COUNT_W'(idx_inc) == msg_q);
		stat.due        = !map_rd && (CMP_W'(age_now) >= CMP_W'(age_q));
		stat.pend_valid = pend_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q        <= AGE_W'(AGE_RESET);
			tick_q       <= '0;
			total_q      <= '0;
			msg_q        <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				age_q <= cfg_wdata;
			end
			if (cmd.tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end
			if (cmd.start_load) begin
				total_q     <= '0;
				msg_q       <= count_sat;
				idx_q       <= '0;
			end else if (cmd.scan_init) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_inc;
			end
			if (map_set) begin
				total_q <= total_inc;
			end
			if (cmd.scan_init) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_set) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_set) begin
			pend_idx_q <= cur_slot;
		end
		if (cmd.ack_read) begin
			ack_idx_q <= in_ack_index;
		end
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				OSEL_SEND: begin
					kind_q        <= KIND_SEND;
					chunk_index_q <= CHIDX_W'(idx_q);
					all_acked_q   <= 1'b0;
					dup_q         <= 1'b0;
					bad_q         <= 1'b0;
					last_q        <= stat.idx_last;
				end
				OSEL_STATUS: begin
					kind_q        <= KIND_STATUS;
					chunk_index_q <= ack_idx_q;
					all_acked_q   <= ack_all;
					dup_q         <= ack_dup;
					bad_q         <= ack_bad;
					last_q        <= 1'b1;
				end
				OSEL_RETX_MID: begin
					kind_q        <= KIND_RETX;
					chunk_index_q <= CHIDX_W'(pend_idx_q);
					all_acked_q   <= 1'b0;
					dup_q         <= 1'b0;
					bad_q         <= 1'b0;
					last_q        <= 1'b0;
				end
				OSEL_RETX_LAST: begin
					kind_q        <= KIND_RETX;
					chunk_index_q <= CHIDX_W'(pend_idx_q);
					all_acked_q   <= 1'b0;
					dup_q         <= 1'b0;
					bad_q         <= 1'b0;
					last_q        <= 1'b1;
				end
				OSEL_DONE: begin
					kind_q        <= KIND_DONE;
					chunk_index_q <= '0;
					all_acked_q   <= (total_q == msg_q);
					dup_q         <= 1'b0;
					bad_q         <= 1'b0;
					last_q        <= 1'b1;
				end
				default: begin
					kind_q        <= KIND_DONE;
					chunk_index_q <= '0;
					all_acked_q   <= 1'b0;
					dup_q         <= 1'b0;
					bad_q         <= 1'b0;
					last_q        <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign out_kind          = kind_q;
	assign out_chunk_index   = chunk_index_q;
	assign out_all_acked     = all_acked_q;
	assign out_duplicate_ack = dup_q;
	assign out_bad_index     = bad_q;
	assign out_last          = last_q;

endmodule

@@ hw/rtl/srs_checker.sv @@
// Port-level checker for the selective-repeat sender scoreboard, bound to the top.
// Depends on srs_pkg and the top level.
module srs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_chunk_index,
	input logic       out_all_acked,
	input logic       out_duplicate_ack,
	input logic       out_bad_index,
	input logic       out_last
);
	import srs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result withdrawn before it was taken.");

	a_ack_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == FUNC_ACK |=> ##1
		out_valid && out_kind == KIND_STATUS && out_last)
		else $error("Acknowledge did not produce a status result.");

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == FUNC_TICK |=> !$rose(out_valid))
		else $error("Tick produced a result.");

	a_send_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_SEND || out_kind == KIND_RETX) |->
		!out_all_acked && !out_duplicate_ack && !out_bad_index)
		else $error("Send or retransmit result carries status flags.");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_DONE |->
		out_last && out_chunk_index == '0 && !out_duplicate_ack && !out_bad_index)
		else $error("Scan-done result is malformed.");

endmodule

bind selective_repeat_sender_scoreboard_unit srs_checker u_srs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.in_func           (in_ch.func),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_kind          (out_ch.kind),
	.out_chunk_index   (out_ch.chunk_index),
	.out_all_acked     (out_ch.all_acked),
	.out_duplicate_ack (out_ch.duplicate_ack),
	.out_bad_index     (out_ch.bad_index),
	.out_last          (out_ch.last)
);

@@ tb/srs_result_checker.sv @@
// Result checker for the selective-repeat sender scoreboard testbench.
// Watches the item, result and age register ports, predicts each result and compares it.
// Depends on srs_pkg, srs_in_if and srs_out_if.
module srs_result_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	srs_in_if                         in_ch,
	srs_out_if                        out_ch,
	input  logic                      cfg_we,
	input  logic [srs_pkg::AGE_W-1:0] cfg_wdata,
	output int                        failures,
	output int                        outstanding
);
	import srs_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [CHIDX_W-1:0] chunk_index;
		logic               all_acked;
		logic               duplicate_ack;
		logic               bad_index;
		logic               last;
	} result_t;

	result_t               expected_results[$];
	result_t               oldest;
	logic [MAX_CHUNKS-1:0] ack_seen;
	logic [STAMP_BITS-1:0] stamp_of[MAX_CHUNKS];
	logic [STAMP_BITS-1:0] now_tick;
	logic [COUNT_W-1:0]    ack_count;
	logic [COUNT_W-1:0]    msg_len;
	logic [AGE_W-1:0]      retx_age;
	int                    fail_total = 0;

	assign failures = fail_total;

	function automatic void push_result(kind_t k, logic [CHIDX_W-1:0] idx, logic all,
		logic dup, logic bad, logic fin);
		result_t item;
		item.kind          = k;
		item.chunk_index   = idx;
		item.all_acked     = all;
		item.duplicate_ack = dup;
		item.bad_index     = bad;
		item.last          = fin;
		expected_results.push_back(item);
	endfunction

	function automatic void predict_item(logic [1:0] func, logic [COUNT_W-1:0] count,
		logic [ACK_W-1:0] ack);
		int                    n;
		logic                  have_held;
		logic [CHIDX_W-1:0]    held_idx;
		logic [STAMP_BITS-1:0] age;
		have_held = 1'b0;
		held_idx  = '0;
		case (func)
			FUNC_START: begin
				n         = (count > MAX_CHUNKS) ? MAX_CHUNKS : int'(count);
				ack_seen  = '0;
				ack_count = '0;
				msg_len   = COUNT_W'(n);
				for (int i = 0; i < n; i++) begin
					stamp_of[i] = now_tick;
					push_result(KIND_SEND, CHIDX_W'(i), 1'b0, 1'b0, 1'b0, i == n - 1);
				end
			end
			FUNC_ACK: begin
				if (ack >= msg_len) begin
					push_result(KIND_STATUS, ack, ack_count == msg_len, 1'b0, 1'b1, 1'b1);
				end else if (ack_seen[ack]) begin
					push_result(KIND_STATUS, ack, ack_count == msg_len, 1'b1, 1'b0, 1'b1);
				end else begin
					ack_seen[ack] = 1'b1;
					ack_count     = ack_count + 1'b1;
					push_result(KIND_STATUS, ack, ack_count == msg_len, 1'b0, 1'b0, 1'b1);
				end
			end
			FUNC_TICK: begin
				now_tick = now_tick + 1'b1;
			end
			default: begin
				for (int i = 0; i < int'(msg_len) && i < MAX_CHUNKS; i++) begin
					age = now_tick - stamp_of[i];
					if (!ack_seen[i] && age >= retx_age) begin
						stamp_of[i] = now_tick;
						if (have_held) begin
							push_result(KIND_RETX, held_idx, 1'b0, 1'b0, 1'b0, 1'b0);
						end
						have_held = 1'b1;
						held_idx  = CHIDX_W'(i);
					end
				end
				if (have_held) begin
					push_result(KIND_RETX, held_idx, 1'b0, 1'b0, 1'b0, 1'b1);
				end else begin
					push_result(KIND_DONE, '0, ack_count == msg_len, 1'b0, 1'b0, 1'b1);
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_seen  = '0;
			now_tick  = '0;
			ack_count = '0;
			msg_len   = '0;
			retx_age  = AGE_W'(AGE_RESET);
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				stamp_of[i] = '0;
			end
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				retx_age = cfg_wdata;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: kind %0d, chunk_index %0d",
						out_ch.kind, out_ch.chunk_index);
					fail_total++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("kind", oldest.kind, out_ch.kind);
					check_field("chunk_index", oldest.chunk_index, out_ch.chunk_index);
					check_field("all_acked", oldest.all_acked, out_ch.all_acked);
					check_field("duplicate_ack", oldest.duplicate_ack, out_ch.duplicate_ack);
					check_field("bad_index", oldest.bad_index, out_ch.bad_index);
					check_field("last", oldest.last, out_ch.last);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_item(in_ch.func, in_ch.chunk_count, in_ch.ack_index);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// Top of the selective-repeat sender scoreboard testbench.
// Drives items, age register writes and receiver stalls; the checker judges the results.
// Depends on srs_pkg, srs_in_if, srs_out_if, srs_result_checker and the block itself.
module tb;
	import srs_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS  = 150;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [AGE_W-1:0] cfg_wdata;
	int               failures;
	int               outstanding;
	int               burst_left  = 0;
	int               items_sent  = 0;
	int               open_chunks = 0;
	int               stall_left  = 0;
	int               stall_mode  = 0;
	int               stall_cycle = 0;

	srs_in_if  in_ch();
	srs_out_if out_ch();

	selective_repeat_sender_scoreboard_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	srs_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(40, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_cycle <= stall_cycle + 1;
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 3) != 0);
			2: out_ch.ready <= ((stall_cycle % 8) < 5);
			default: out_ch.ready <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic send_item(func_t f, logic [COUNT_W-1:0] cnt, logic [ACK_W-1:0] ack);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= f;
		in_ch.chunk_count <= cnt;
		in_ch.ack_index   <= ack;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		items_sent++;
		if (f == FUNC_START) begin
			open_chunks = (cnt > MAX_CHUNKS) ? MAX_CHUNKS : int'(cnt);
		end
	endtask

	task automatic send_start(logic [COUNT_W-1:0] cnt);
		send_item(FUNC_START, cnt, ACK_W'($urandom_range(0, 255)));
	endtask

	task automatic send_ack(logic [ACK_W-1:0] idx);
		send_item(FUNC_ACK, COUNT_W'($urandom_range(0, 127)), idx);
	endtask

	task automatic send_tick();
		send_item(FUNC_TICK, COUNT_W'($urandom_range(0, 127)), ACK_W'($urandom_range(0, 255)));
	endtask

	task automatic send_scan();
		send_item(FUNC_SCAN, COUNT_W'($urandom_range(0, 127)), ACK_W'($urandom_range(0, 255)));
	endtask

	task automatic await_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_age(logic [AGE_W-1:0] age);
		cfg_we    <= 1'b1;
		cfg_wdata <= age;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int r;
		int steps;
		int random_from;
		in_ch.valid       <= 1'b0;
		in_ch.func        <= FUNC_START;
		in_ch.chunk_count <= '0;
		in_ch.ack_index   <= '0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		arst_n            <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_ack(8'd0);
		send_scan();
		send_tick();
		send_start(7'd0);
		send_start(7'd1);
		send_ack(8'd0);
		send_ack(8'd0);
		send_ack(8'd1);
		send_ack(8'd255);
		send_scan();
		send_start(7'd127);
		send_scan();
		send_ack(8'd63);
		send_ack(8'd64);
		await_idle();
		write_age('0);
		send_scan();
		send_start(7'd3);
		await_idle();
		write_age(16'd1);
		send_tick();
		send_scan();
		send_ack(8'd1);
		send_tick();
		send_scan();
		send_ack(8'd0);
		send_ack(8'd2);
		send_scan();

		// The longest age: no chunk comes due within a few ticks.
		await_idle();
		write_age(16'hFFFF);
		send_start(7'd2);
		send_scan();
		send_tick();
		send_scan();

		random_from = items_sent;
		while (items_sent - random_from < RANDOM_ITEMS) begin
			await_idle();
			r = $urandom_range(0, 9);
			if (r == 0) begin
				write_age(AGE_W'($urandom_range(1, 65535)));
			end else if (r == 1) begin
				write_age(AGE_W'(AGE_RESET));
			end else begin
				write_age(AGE_W'($urandom_range(1, 6)));
			end
			r = $urandom_range(0, 11);
			if (r < 2) begin
				send_start(COUNT_W'($urandom_range(0, 127)));
			end else if (r < 4) begin
				send_start(COUNT_W'($urandom_range(17, 64)));
			end else begin
				send_start(COUNT_W'($urandom_range(1, 16)));
			end
			steps = $urandom_range(8, 30);
			repeat (steps) begin
				r = $urandom_range(0, 99);
				if (r < 40 && open_chunks > 0) begin
					send_ack(ACK_W'($urandom_range(0, open_chunks - 1)));
				end else if (r < 55) begin
					repeat ($urandom_range(1, 3)) send_tick();
				end else if (r < 75) begin
					send_scan();
				end else if (r < 85) begin
					send_ack(ACK_W'($urandom_range(0, 255)));
				end else begin
					send_item(func_t'($urandom_range(0, 3)), COUNT_W'($urandom_range(0, 127)),
						ACK_W'($urandom_range(0, 255)));
				end
			end
		end

		await_idle();
		if (failures == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#18000000;
		$display("tb failed");
		$finish;
	end

endmodule
